@@ rtl/gse_pkg.sv @@
package gse_pkg;

    // Frame geometry limits
    localparam int MAX_WIDTH    = 1024;
    localparam int HEIGHT_LIMIT = 4096;
    localparam int MIN_SIDE     = 3;

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int WCFG_W = 11;
    localparam int HCFG_W = 13;
    localparam int ROW_W  = 13;
    localparam int POS_W  = 15;

    // Configuration port
    localparam int CFG_DATA_W = 13;
    localparam int CFG_IDX_W  = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'b1;
    localparam logic [WCFG_W-1:0] WIDTH_RESET  = 11'd496;
    localparam logic [HCFG_W-1:0] HEIGHT_RESET = 13'd372;

    // Field widths
    localparam int PIX_W  = 8;
    localparam int SM_W   = 12;
    localparam int GRAD_W = 15;
    localparam int MAG_W  = 15;

    // Square root unit
    localparam int RAD_W      = 30;
    localparam int REM_W      = 18;
    localparam int ROOT_STEPS = RAD_W / 2;
    localparam int STEP_W     = $clog2(ROOT_STEPS);

    // Decoupling queue
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // One classified item: data plus all padding masks for both windows
    typedef struct packed {
        logic [PIX_W-1:0] x;
        logic [COL_W-1:0] in_col;
        logic [COL_W-1:0] sm_col;
        logic [2:0]       g_row;
        logic             g_c0;
        logic             g_c2;
        logic [2:0]       s_row;
        logic             s_c0;
        logic             s_c2;
        logic             res;
        logic             eof;
    } t_item;

endpackage

@@ rtl/gse_front.sv @@
module gse_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [gse_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [gse_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_valid,
    input  logic                           i_cmd,
    input  logic [gse_pkg::PIX_W-1:0]      i_pixel,
    input  logic                           i_full,
    output logic                           o_push,
    output gse_pkg::t_item                 o_item
);

    logic [gse_pkg::WCFG_W-1:0] r_cfg_w;
    logic [gse_pkg::HCFG_W-1:0] r_cfg_h;
    logic [gse_pkg::COL_W-1:0]  r_col;
    logic [gse_pkg::ROW_W-1:0]  r_row;

    logic [gse_pkg::WCFG_W-1:0] wd;
    logic [gse_pkg::HCFG_W-1:0] ht;
    logic [gse_pkg::COL_W-1:0]  wm1;
    logic [gse_pkg::COL_W-1:0]  cc;
    logic [gse_pkg::COL_W-1:0]  dc;
    logic signed [gse_pkg::POS_W-1:0] cr;
    logic signed [gse_pkg::POS_W-1:0] dr;
    logic signed [gse_pkg::POS_W-1:0] ht_s;
    logic in_frame;
    logic accept;

    function automatic logic row_ok(input logic signed [gse_pkg::POS_W-1:0] r,
                                    input logic signed [gse_pkg::POS_W-1:0] h);
        return (r >= 0) && (r < h);
    endfunction

    // Effective geometry, saturated to the legal range
    always_comb begin
        wd = r_cfg_w;
        if (r_cfg_w < gse_pkg::WCFG_W'(gse_pkg::MIN_SIDE)) wd = gse_pkg::WCFG_W'(gse_pkg::MIN_SIDE);
        if (r_cfg_w > gse_pkg::WCFG_W'(gse_pkg::MAX_WIDTH)) wd = gse_pkg::WCFG_W'(gse_pkg::MAX_WIDTH);
        ht = r_cfg_h;
        if (r_cfg_h < gse_pkg::HCFG_W'(gse_pkg::MIN_SIDE)) ht = gse_pkg::HCFG_W'(gse_pkg::MIN_SIDE);
        if (r_cfg_h > gse_pkg::HCFG_W'(gse_pkg::HEIGHT_LIMIT)) begin
            ht = gse_pkg::HCFG_W'(gse_pkg::HEIGHT_LIMIT);
        end
    end

    // Window centers: smoothing lags input by a row and a column, gradient lags again
    always_comb begin
        wm1  = gse_pkg::COL_W'(wd - gse_pkg::WCFG_W'(1));
        ht_s = $signed({2'b00, ht});
        cc   = (r_col != '0) ? r_col - gse_pkg::COL_W'(1) : wm1;
        cr   = $signed({2'b00, r_row}) - ((r_col != '0) ? gse_pkg::POS_W'(1) : gse_pkg::POS_W'(2));
        dc   = (cc != '0) ? cc - gse_pkg::COL_W'(1) : wm1;
        dr   = cr - ((cc != '0) ? gse_pkg::POS_W'(1) : gse_pkg::POS_W'(2));
        in_frame = ({2'b00, r_row} < {1'b0, ht});
    end

    // Classify the item and build its masks
    always_comb begin
        o_item.x      = in_frame ? i_pixel : '0;
        o_item.in_col = r_col;
        o_item.sm_col = cc;
        for (int i = 0; i < 3; i++) begin
            o_item.g_row[i] = row_ok(cr, ht_s) && row_ok(cr - gse_pkg::POS_W'(1) + gse_pkg::POS_W'(i), ht_s);
            o_item.s_row[i] = row_ok(dr, ht_s) && row_ok(dr - gse_pkg::POS_W'(1) + gse_pkg::POS_W'(i), ht_s);
        end
        o_item.g_c0 = (cc == '0);
        o_item.g_c2 = (cc == wm1);
        o_item.s_c0 = (dc == '0);
        o_item.s_c2 = (dc == wm1);
        o_item.res  = row_ok(dr, ht_s);
        o_item.eof  = row_ok(dr, ht_s) && (dr == ht_s - gse_pkg::POS_W'(1)) && (dc == wm1);
    end

    // Drain ticks inside the frame are dropped
    assign accept = i_valid && !i_full;
    assign o_push = accept && !(i_cmd && in_frame);

    // Configuration and position counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w <= gse_pkg::WIDTH_RESET;
            r_cfg_h <= gse_pkg::HEIGHT_RESET;
            r_col   <= '0;
            r_row   <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                gse_pkg::CFG_FRAME_WIDTH:  r_cfg_w <= i_cfg_data[gse_pkg::WCFG_W-1:0];
                gse_pkg::CFG_FRAME_HEIGHT: r_cfg_h <= i_cfg_data[gse_pkg::HCFG_W-1:0];
                default: ;
            endcase
            r_col <= '0;
            r_row <= '0;
        end else if (o_push) begin
            priority if (o_item.eof) begin
                r_col <= '0;
                r_row <= '0;
            end else if (r_col == wm1) begin
                r_col <= '0;
                r_row <= r_row + gse_pkg::ROW_W'(1);
            end else begin
                r_col <= r_col + gse_pkg::COL_W'(1);
            end
        end
    end

endmodule

@@ rtl/gse_queue.sv @@
module gse_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  gse_pkg::t_item i_item,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_empty,
    output gse_pkg::t_item o_item
);

    gse_pkg::t_item r_mem [gse_pkg::QUEUE_DEPTH];
    logic [gse_pkg::QPTR_W-1:0] r_wr;
    logic [gse_pkg::QPTR_W-1:0] r_rd;
    logic [gse_pkg::QPTR_W:0]   r_count;

    assign o_full  = (r_count == (gse_pkg::QPTR_W+1)'(gse_pkg::QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_item  = r_mem[r_rd];

    // Pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) r_wr <= r_wr + gse_pkg::QPTR_W'(1);
            if (i_pop)  r_rd <= r_rd + gse_pkg::QPTR_W'(1);
            if (i_push && !i_pop)      r_count <= r_count + (gse_pkg::QPTR_W+1)'(1);
            else if (i_pop && !i_push) r_count <= r_count - (gse_pkg::QPTR_W+1)'(1);
        end
    end

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr] <= i_item;
    end

endmodule

@@ rtl/gse_back.sv @@
module gse_back (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_empty,
    input  gse_pkg::t_item                      i_item,
    output logic                                o_pop,
    input  logic                                i_stall,
    output logic                                o_valid,
    output logic [gse_pkg::SM_W-1:0]            o_smoothed,
    output logic signed [gse_pkg::GRAD_W-1:0]   o_grad_x,
    output logic signed [gse_pkg::GRAD_W-1:0]   o_grad_y,
    output logic [gse_pkg::MAG_W-1:0]           o_magnitude,
    output logic                                o_end_of_frame
);

    typedef enum logic [9:0] {
        S_IDLE   = 10'b0000000001,
        S_RD_IN  = 10'b0000000010,
        S_WIN_IN = 10'b0000000100,
        S_SUM_IN = 10'b0000001000,
        S_WIN_SM = 10'b0000010000,
        S_GRAD   = 10'b0000100000,
        S_SQX    = 10'b0001000000,
        S_SQY    = 10'b0010000000,
        S_ROOT   = 10'b0100000000,
        S_OUT    = 10'b1000000000
    } t_state;

    t_state r_state, n_state;
    gse_pkg::t_item r_item;

    // Line stores: two lines for input pixels, two for smoothed values
    logic [gse_pkg::PIX_W-1:0] m_in0 [gse_pkg::MAX_WIDTH];
    logic [gse_pkg::PIX_W-1:0] m_in1 [gse_pkg::MAX_WIDTH];
    logic [gse_pkg::SM_W-1:0]  m_sm0 [gse_pkg::MAX_WIDTH];
    logic [gse_pkg::SM_W-1:0]  m_sm1 [gse_pkg::MAX_WIDTH];
    logic [gse_pkg::PIX_W-1:0] r_top_in, r_mid_in;
    logic [gse_pkg::SM_W-1:0]  r_top_sm, r_mid_sm;

    logic [gse_pkg::PIX_W-1:0] r_win_in [3][3];
    logic [gse_pkg::SM_W-1:0]  r_win_sm [3][3];
    logic [gse_pkg::SM_W-1:0]  r_s;

    logic signed [gse_pkg::GRAD_W-1:0] r_gx, r_gy;
    logic [gse_pkg::RAD_W-1:0]  r_rad;
    logic [gse_pkg::REM_W-1:0]  r_rem;
    logic [gse_pkg::MAG_W-1:0]  r_root;
    logic [gse_pkg::STEP_W-1:0] r_cnt;
    logic                       r_out_valid;

    logic [gse_pkg::SM_W-1:0] gsum;
    logic signed [gse_pkg::GRAD_W:0] gx_sum, gy_sum;
    logic [gse_pkg::GRAD_W-2:0] ax, ay;
    logic [gse_pkg::REM_W-1:0] rem_sh, trial;
    logic out_free;

    assign out_free = !r_out_valid || !i_stall;
    assign o_pop    = (r_state == S_IDLE) && !i_empty;

    // Sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (!i_empty) n_state = S_RD_IN;
            S_RD_IN:  n_state = S_WIN_IN;
            S_WIN_IN: n_state = S_SUM_IN;
            S_SUM_IN: n_state = S_WIN_SM;
            S_WIN_SM: n_state = S_GRAD;
            S_GRAD:   n_state = r_item.res ? S_SQX : S_IDLE;
            S_SQX:    n_state = S_SQY;
            S_SQY:    n_state = S_ROOT;
            S_ROOT:   if (r_cnt == gse_pkg::STEP_W'(gse_pkg::ROOT_STEPS - 1)) n_state = S_OUT;
            S_OUT:    if (out_free) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // Gaussian sum over the masked input window
    always_comb begin
        logic m;
        gsum = '0;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                m = r_item.g_row[i] && !(j == 0 && r_item.g_c0) && !(j == 2 && r_item.g_c2);
                if (m) begin
                    gsum = gsum + (gse_pkg::SM_W'(r_win_in[i][j])
                                   << ((i == 1 ? 1 : 0) + (j == 1 ? 1 : 0)));
                end
            end
        end
    end

    // Sobel x and y over the masked smoothed window
    always_comb begin
        logic signed [gse_pkg::GRAD_W:0] mv [3][3];
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                mv[i][j] = (r_item.s_row[i] && !(j == 0 && r_item.s_c0)
                            && !(j == 2 && r_item.s_c2))
                           ? $signed({4'b0000, r_win_sm[i][j]}) : '0;
            end
        end
        gx_sum = (mv[0][2] - mv[0][0]) + ((mv[1][2] - mv[1][0]) <<< 1) + (mv[2][2] - mv[2][0]);
        gy_sum = (mv[2][0] - mv[0][0]) + ((mv[2][1] - mv[0][1]) <<< 1) + (mv[2][2] - mv[0][2]);
    end

    // Magnitudes of the gradients and one root digit step
    always_comb begin
        ax     = (gse_pkg::GRAD_W-1)'(r_gx < 0 ? -r_gx : r_gx);
        ay     = (gse_pkg::GRAD_W-1)'(r_gy < 0 ? -r_gy : r_gy);
        rem_sh = {r_rem[gse_pkg::REM_W-3:0], r_rad[gse_pkg::RAD_W-1 -: 2]};
        trial  = gse_pkg::REM_W'({r_root, 2'b01});
    end

    // Line store access: read in one state, write back in a later one
    always_ff @(posedge i_clk) begin
        if (r_state == S_RD_IN) begin
            r_top_in <= m_in0[r_item.in_col];
            r_mid_in <= m_in1[r_item.in_col];
        end
        if (r_state == S_WIN_IN) begin
            m_in0[r_item.in_col] <= r_mid_in;
            m_in1[r_item.in_col] <= r_item.x;
        end
        if (r_state == S_SUM_IN) begin
            r_top_sm <= m_sm0[r_item.sm_col];
            r_mid_sm <= m_sm1[r_item.sm_col];
        end
        if (r_state == S_WIN_SM) begin
            m_sm0[r_item.sm_col] <= r_mid_sm;
            m_sm1[r_item.sm_col] <= r_s;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        if (o_pop) r_item <= i_item;
        if (r_state == S_WIN_IN) begin
            for (int k = 0; k < 3; k++) begin
                r_win_in[k][0] <= r_win_in[k][1];
                r_win_in[k][1] <= r_win_in[k][2];
            end
            r_win_in[0][2] <= r_top_in;
            r_win_in[1][2] <= r_mid_in;
            r_win_in[2][2] <= r_item.x;
        end
        if (r_state == S_SUM_IN) r_s <= gsum;
        if (r_state == S_WIN_SM) begin
            for (int k = 0; k < 3; k++) begin
                r_win_sm[k][0] <= r_win_sm[k][1];
                r_win_sm[k][1] <= r_win_sm[k][2];
            end
            r_win_sm[0][2] <= r_top_sm;
            r_win_sm[1][2] <= r_mid_sm;
            r_win_sm[2][2] <= r_s;
        end
        if (r_state == S_GRAD) begin
            r_gx <= gse_pkg::GRAD_W'(gx_sum);
            r_gy <= gse_pkg::GRAD_W'(gy_sum);
        end
        if (r_state == S_SQX) r_rad <= gse_pkg::RAD_W'(ax * ax);
        if (r_state == S_SQY) begin
            r_rad  <= r_rad + gse_pkg::RAD_W'(ay * ay);
            r_rem  <= '0;
            r_root <= '0;
            r_cnt  <= '0;
        end
        if (r_state == S_ROOT) begin
            r_rad <= r_rad << 2;
            r_cnt <= r_cnt + gse_pkg::STEP_W'(1);
            if (rem_sh >= trial) begin
                r_rem  <= rem_sh - trial;
                r_root <= {r_root[gse_pkg::MAG_W-2:0], 1'b1};
            end else begin
                r_rem  <= rem_sh;
                r_root <= {r_root[gse_pkg::MAG_W-2:0], 1'b0};
            end
        end
        if (r_state == S_OUT && out_free) begin
            o_smoothed     <= r_win_sm[1][1];
            o_grad_x       <= r_gx;
            o_grad_y       <= r_gy;
            o_magnitude    <= r_root;
            o_end_of_frame <= r_item.eof;
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_OUT && out_free) r_out_valid <= 1'b1;
            else if (!i_stall)                r_out_valid <= 1'b0;
        end
    end

    assign o_valid = r_out_valid;

endmodule

@@ rtl/gaussian_sobel_edge_stream.sv @@
// A result leaves 2*W+2 items after its pixel. The back end takes no new item until
// it has finished the last one: its sequencer steps through the window states and, for
// an item that gives a result, the 15-step bit-serial square root, and a downstream
// stall holds it in its output state; a two-entry queue decouples intake from it.
// Reset (synchronous, active low) restores 496x372 and restarts the frame position.
module gaussian_sobel_edge_stream (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [gse_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [gse_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic                                i_cmd,
    input  logic [gse_pkg::PIX_W-1:0]           i_pixel,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic [gse_pkg::SM_W-1:0]            o_smoothed,
    output logic signed [gse_pkg::GRAD_W-1:0]   o_grad_x,
    output logic signed [gse_pkg::GRAD_W-1:0]   o_grad_y,
    output logic [gse_pkg::MAG_W-1:0]           o_magnitude,
    output logic                                o_end_of_frame
);

    gse_pkg::t_item w_push_item, w_head;
    logic w_push, w_pop, w_full, w_empty;

    assign o_stall = w_full;

    // Intake and classification
    gse_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_valid),
        .i_cmd       (i_cmd),
        .i_pixel     (i_pixel),
        .i_full      (w_full),
        .o_push      (w_push),
        .o_item      (w_push_item)
    );

    // Queue between intake and filter back end
    gse_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_push_item),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_empty (w_empty),
        .o_item  (w_head)
    );

    // Filters, gradient and root
    gse_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_empty        (w_empty),
        .i_item         (w_head),
        .o_pop          (w_pop),
        .i_stall        (i_stall),
        .o_valid        (o_valid),
        .o_smoothed     (o_smoothed),
        .o_grad_x       (o_grad_x),
        .o_grad_y       (o_grad_y),
        .o_magnitude    (o_magnitude),
        .o_end_of_frame (o_end_of_frame)
    );

`ifndef ASSERT_OFF
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_full) else $error("transfer pushed into a full queue");
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_empty) else $error("back end popped an empty queue");
    a_eof_res: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push && w_push_item.eof |-> w_push_item.res)
        else $error("end of frame on an item without a result");
`endif

endmodule
